>>> sv/gate_step_sequencer_macros.svh
// Assertion macros for the gate step sequencer.
`ifndef GATE_STEP_SEQUENCER_MACROS_SVH
`define GATE_STEP_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property with async active-low reset disable.
`define GSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapped implication form.
`define GSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication form.
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GSS_ASSERT(label, clk, rst_n, prop, msg)
`define GSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/gss_pkg.sv
// Shared types and constants for the gate step sequencer.
package gss_pkg;

    localparam int NUM_STEPS = 16;
    localparam int LAST_W    = 4;
    localparam int MAX_LAST  = (NUM_STEPS - 1 > 15) ? 15 : NUM_STEPS - 1;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LAST_STEP  = 3'd0,
        REG_PLAY_MODE  = 3'd1,
        REG_CV_MODE    = 3'd2,
        REG_STEP_GATES = 3'd3,
        REG_TRIG_TICKS = 3'd4,
        REG_EOC_TICKS  = 3'd5
    } reg_idx_t;

    localparam logic [1:0] PLAY_FWD = 2'd0;
    localparam logic [1:0] PLAY_REV = 2'd1;

    localparam logic [LAST_W-1:0] RST_LAST_STEP  = 4'd15;
    localparam logic [1:0]        RST_PLAY_MODE  = PLAY_FWD;
    localparam logic              RST_CV_MODE    = 1'b0;
    localparam logic [15:0]       RST_STEP_GATES = 16'h0000;
    localparam logic [15:0]       RST_TRIG_TICKS = 16'd9;
    localparam logic [15:0]       RST_EOC_TICKS  = 16'd22;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef struct packed {
        logic [LAST_W-1:0] last_step;
        logic [1:0]        play_mode;
        logic              cv_mode;
        logic [15:0]       step_gates;
        logic [15:0]       trig_ticks;
        logic [15:0]       eoc_ticks;
    } cfg_t;

    typedef struct packed {
        logic              cv_zero;
        logic              cv_load;
        logic              step_valid;
        logic [LAST_W-1:0] step_index;
        logic              eoc_out;
        logic              trig_out;
        logic              gate_out;
    } res_t;

endpackage

>>> sv/gss_apb_regs.sv
// APB configuration register file for the gate step sequencer.
module gss_apb_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gss_pkg::ADDR_W-1:0]  paddr,
    input  logic [gss_pkg::DATA_W-1:0]  pwdata,
    output logic [gss_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output gss_pkg::cfg_t               cfg
);

    gss_pkg::cfg_t cfg_reg;
    gss_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                gss_pkg::REG_LAST_STEP:  cfg_next.last_step  = pwdata[3:0];
                gss_pkg::REG_PLAY_MODE:  cfg_next.play_mode  = pwdata[1:0];
                gss_pkg::REG_CV_MODE:    cfg_next.cv_mode    = pwdata[0];
                gss_pkg::REG_STEP_GATES: cfg_next.step_gates = pwdata[15:0];
                gss_pkg::REG_TRIG_TICKS: cfg_next.trig_ticks = pwdata[15:0];
                gss_pkg::REG_EOC_TICKS:  cfg_next.eoc_ticks  = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.last_step  <= gss_pkg::RST_LAST_STEP;
            cfg_reg.play_mode  <= gss_pkg::RST_PLAY_MODE;
            cfg_reg.cv_mode    <= gss_pkg::RST_CV_MODE;
            cfg_reg.step_gates <= gss_pkg::RST_STEP_GATES;
            cfg_reg.trig_ticks <= gss_pkg::RST_TRIG_TICKS;
            cfg_reg.eoc_ticks  <= gss_pkg::RST_EOC_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            gss_pkg::REG_LAST_STEP:  prdata = {28'd0, cfg_reg.last_step};
            gss_pkg::REG_PLAY_MODE:  prdata = {30'd0, cfg_reg.play_mode};
            gss_pkg::REG_CV_MODE:    prdata = {31'd0, cfg_reg.cv_mode};
            gss_pkg::REG_STEP_GATES: prdata = {16'd0, cfg_reg.step_gates};
            gss_pkg::REG_TRIG_TICKS: prdata = {16'd0, cfg_reg.trig_ticks};
            gss_pkg::REG_EOC_TICKS:  prdata = {16'd0, cfg_reg.eoc_ticks};
            default:                 prdata = '0;
        endcase
    end

endmodule

>>> sv/gss_step_core.sv
// Step state and per-tick next-state logic of the gate step sequencer.
module gss_step_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic          clock_level,
    input  logic          reset_level,
    input  logic          reset_button,
    input  gss_pkg::cfg_t cfg,
    output gss_pkg::res_t res
);

    logic                       clock_prev_reg, clock_prev_next;
    logic                       reset_prev_reg, reset_prev_next;
    logic                       pos_valid_reg,  pos_valid_next;
    logic [gss_pkg::LAST_W-1:0] pos_reg,        pos_next;
    logic                       gate_reg,       gate_next;
    logic [15:0]                trig_left_reg,  trig_left_next;
    logic [15:0]                eoc_left_reg,   eoc_left_next;
    logic [15:0]                lfsr_reg,       lfsr_next;

    logic                       rst_lvl;
    logic                       rst_edge;
    logic                       clk_edge;
    logic [gss_pkg::LAST_W-1:0] eff_last;
    logic                       pv_a;
    logic                       wrap;
    logic [15:0]                lfsr_adv;
    logic [20:0]                rand_prod;
    logic                       gbit;
    logic                       load;
    logic                       zero;
    logic [15:0]                trig_cur;
    logic [15:0]                eoc_cur;

    assign rst_lvl  = reset_level | reset_button;
    assign rst_edge = rst_lvl & ~reset_prev_reg;
    assign clk_edge = clock_level & ~clock_prev_reg;

    assign eff_last = (cfg.last_step > gss_pkg::LAST_W'(gss_pkg::MAX_LAST)) ?
                      gss_pkg::LAST_W'(gss_pkg::MAX_LAST) : cfg.last_step;

    // Galois step, then scale into 0..last
    assign lfsr_adv  = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? gss_pkg::LFSR_MASK : 16'h0000);
    assign rand_prod = 21'(lfsr_adv) * 21'({1'b0, eff_last} + 5'd1);

    always_comb
    begin
        pv_a      = pos_valid_reg & ~rst_edge;
        pos_next  = pos_reg;
        gate_next = rst_edge ? 1'b0 : gate_reg;
        zero      = rst_edge;
        load      = 1'b0;
        wrap      = 1'b0;
        lfsr_next = lfsr_reg;

        if (clk_edge)
        begin
            case (cfg.play_mode)
                gss_pkg::PLAY_FWD:
                begin
                    if (!pv_a)
                        pos_next = '0;
                    else if (pos_reg >= eff_last)
                    begin
                        pos_next = '0;
                        wrap     = 1'b1;
                    end
                    else
                        pos_next = pos_reg + gss_pkg::LAST_W'(1);
                end
                gss_pkg::PLAY_REV:
                begin
                    if (!pv_a || pos_reg == '0)
                    begin
                        pos_next = eff_last;
                        wrap     = 1'b1;
                    end
                    else if (pos_reg > eff_last)
                        pos_next = eff_last;
                    else
                        pos_next = pos_reg - gss_pkg::LAST_W'(1);
                end
                default:
                begin
                    lfsr_next = lfsr_adv;
                    pos_next  = rand_prod[16 +: gss_pkg::LAST_W];
                end
            endcase
        end

        pos_valid_next = pv_a | clk_edge;
        gbit           = cfg.step_gates[pos_next];

        trig_cur = trig_left_reg;
        if (clk_edge)
        begin
            if (gbit)
            begin
                gate_next = 1'b1;
                trig_cur  = cfg.trig_ticks;
                load      = ~cfg.cv_mode;
            end
            else
            begin
                gate_next = 1'b0;
                zero      = 1'b1;
            end
        end
        eoc_cur = wrap ? cfg.eoc_ticks : eoc_left_reg;

        // follow mode reloads every tick on a gated step
        if (cfg.cv_mode && pos_valid_next && gbit)
            load = 1'b1;
        if (load)
            zero = 1'b0;

        trig_left_next  = trig_cur - {15'd0, |trig_cur};
        eoc_left_next   = eoc_cur - {15'd0, |eoc_cur};
        clock_prev_next = clock_level;
        reset_prev_next = rst_lvl;

        res.gate_out   = gate_next;
        res.trig_out   = |trig_cur;
        res.eoc_out    = |eoc_cur;
        res.step_index = pos_valid_next ? pos_next : '0;
        res.step_valid = pos_valid_next;
        res.cv_load    = load;
        res.cv_zero    = zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_prev_reg <= 1'b0;
            reset_prev_reg <= 1'b0;
            pos_valid_reg  <= 1'b0;
            pos_reg        <= '0;
            gate_reg       <= 1'b0;
            trig_left_reg  <= '0;
            eoc_left_reg   <= '0;
            lfsr_reg       <= gss_pkg::LFSR_SEED;
        end
        else if (step_en)
        begin
            clock_prev_reg <= clock_prev_next;
            reset_prev_reg <= reset_prev_next;
            pos_valid_reg  <= pos_valid_next;
            pos_reg        <= pos_next;
            gate_reg       <= gate_next;
            trig_left_reg  <= trig_left_next;
            eoc_left_reg   <= eoc_left_next;
            lfsr_reg       <= lfsr_next;
        end
    end

endmodule

>>> sv/gate_step_sequencer.sv
// Gate step sequencer top level: stream ports, input stage, result register.
//
// One input transaction per sample tick on s_axis (clock_level, reset_level,
// reset_button); one result transaction per input on m_axis (gate, trigger,
// end-of-cycle, step index and valid, CV load/zero strobes for an external
// S&H on the selected channel). Registers are written over the APB port;
// the user must write them only while the stream is idle, which the block
// itself does not enforce; pready is tied high.
// Path: an input transaction is held in the input register until the result
// register frees up; its result is then registered and shown on m_axis.
// Throughput: one transaction per cycle while m_axis_tready stays high, the
// step logic between the two registers being combinational; the step state
// updates in the cycle the input register hands its item on.
// Reset (rst_n low, async): stages empty, no step selected, pulses idle,
// LFSR at its seed, registers at their defaults.
// Receiver stall: the result register holds; the input register keeps one
// more item, then s_axis_tready drops until m_axis_tready returns.
`include "gate_step_sequencer_macros.svh"

module gate_step_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gss_pkg::ADDR_W-1:0]  paddr,
    input  logic [gss_pkg::DATA_W-1:0]  pwdata,
    output logic [gss_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // clock_level, reset_level, reset_button, 0
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata   // gate_out, trig_out, eoc_out,
                                                       // step_index[3:0], step_valid,
                                                       // cv_load, cv_zero, 0
);

    gss_pkg::cfg_t cfg;
    gss_pkg::res_t res;
    gss_pkg::res_t res_reg;

    logic       in_valid_reg, in_valid_next;
    logic [2:0] in_data_reg;
    logic       out_valid_reg, out_valid_next;
    logic       advance;
    logic       in_take;

    // assertion terms
    logic       load_zero_both;
    logic       no_step_out;
    logic       no_step_quiet;
    logic [3:0] in_stage;

    gss_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // item moves from input register to result register when the latter frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    gss_step_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .clock_level  (in_data_reg[0]),
        .reset_level  (in_data_reg[1]),
        .reset_button (in_data_reg[2]),
        .cfg          (cfg),
        .res          (res)
    );

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= s_axis_tdata[2:0];
        if (advance)
            res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg};

    assign load_zero_both = m_axis_tvalid && res_reg.cv_load && res_reg.cv_zero;
    assign no_step_out    = m_axis_tvalid && !res_reg.step_valid;
    assign no_step_quiet  = (res_reg.step_index == 4'd0) && !res_reg.gate_out && !res_reg.cv_load;
    assign in_stage       = {in_valid_reg, in_data_reg};

    `GSS_ASSERT(a_load_zero_excl, clk, rst_n, !load_zero_both, "cv_load with cv_zero")
    `GSS_ASSERT_IMPLY(a_idle_step, clk, rst_n, no_step_out, no_step_quiet, "output with no step")
    `GSS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !advance, $stable(in_stage), "held lost")
    `GSS_ASSERT_NEXT(a_out_src, clk, rst_n, advance, m_axis_tvalid, "result transaction missing")

endmodule

>>> bench/tb_gate_step_sequencer.sv
// Self-checking testbench for the gate step sequencer: predicted ticks versus stream results.
module tb_gate_step_sequencer;
    import gss_pkg::*;

    // Play mode codes beyond the two the package names; code 3 also draws at random.
    localparam logic [1:0] PLAY_RAND     = 2'd2;
    localparam logic [1:0] PLAY_RAND_ALT = 2'd3;
    localparam logic       CV_SAMPLE     = 1'b0;
    localparam logic       CV_FOLLOW     = 1'b1;

    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_TICKS  = 60;
    localparam int NUM_PHASES   = 8;
    localparam int LONG_HOLD    = 64;
    localparam int HOLD_AFTER   = 230;

    // Opening ticks, {reset_button, reset_level, clock_level}: clock edges on alternate
    // ticks, a reset edge from the level, a button press together with a clock edge,
    // then a clock edge while reset is held.
    localparam logic [2:0] OPENING_TICKS [12] = '{
        3'b001, 3'b000, 3'b001, 3'b000, 3'b001, 3'b000,
        3'b001, 3'b010, 3'b000, 3'b101, 3'b110, 3'b111
    };

    // Tick-by-tick predictor of the sequencer and the queue of results it expects.
    class step_predictor;
        logic [LAST_W-1:0] last_step;
        logic [1:0]        play_mode;
        logic              cv_mode;
        logic [15:0]       step_gates;
        logic [15:0]       trig_ticks;
        logic [15:0]       eoc_ticks;

        logic        clock_prev;
        logic        reset_prev;
        int          position;
        logic        gate_level;
        logic [15:0] trig_left;
        logic [15:0] eoc_left;
        logic [15:0] lfsr;

        res_t expected_ticks[$];
        int   mismatches;
        int   checked;

        function new();
            last_step  = RST_LAST_STEP;
            play_mode  = RST_PLAY_MODE;
            cv_mode    = RST_CV_MODE;
            step_gates = RST_STEP_GATES;
            trig_ticks = RST_TRIG_TICKS;
            eoc_ticks  = RST_EOC_TICKS;
            clock_prev = 1'b0;
            reset_prev = 1'b0;
            position   = -1;
            gate_level = 1'b0;
            trig_left  = '0;
            eoc_left   = '0;
            lfsr       = LFSR_SEED;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_LAST_STEP:  last_step  = value[LAST_W-1:0];
                REG_PLAY_MODE:  play_mode  = value[1:0];
                REG_CV_MODE:    cv_mode    = value[0];
                REG_STEP_GATES: step_gates = value[15:0];
                REG_TRIG_TICKS: trig_ticks = value[15:0];
                REG_EOC_TICKS:  eoc_ticks  = value[15:0];
                default: ;
            endcase
        endfunction

        function bit gate_bit(int p);
            if (p < 0 || p > 15)
                return 1'b0;
            return step_gates[p];
        endfunction

        function void take_tick(logic clock_level, logic reset_level, logic reset_button);
            res_t        r;
            logic        rst_lvl;
            logic        load;
            logic        zero;
            logic        wrap;
            int unsigned last;
            int unsigned draw;
            rst_lvl = reset_level | reset_button;
            last    = (last_step > NUM_STEPS - 1) ? NUM_STEPS - 1 : last_step;
            load    = 1'b0;
            zero    = 1'b0;
            wrap    = 1'b0;

            // reset edge deselects; pulses already running keep going
            if (rst_lvl && !reset_prev)
            begin
                position   = -1;
                gate_level = 1'b0;
                zero       = 1'b1;
            end
            reset_prev = rst_lvl;

            if (clock_level && !clock_prev)
            begin
                if (play_mode == PLAY_FWD)
                begin
                    if (position < 0)
                        position = 0;
                    else if (position >= int'(last))
                    begin
                        position = 0;
                        wrap     = 1'b1;
                    end
                    else
                        position++;
                end
                else if (play_mode == PLAY_REV)
                begin
                    if (position <= 0)
                    begin
                        position = int'(last);
                        wrap     = 1'b1;
                    end
                    else if (position > int'(last))
                        position = int'(last);
                    else
                        position--;
                end
                else
                begin
                    // Galois LFSR, then scale the draw into 0..last
                    if (lfsr[0])
                        lfsr = (lfsr >> 1) ^ LFSR_MASK;
                    else
                        lfsr = lfsr >> 1;
                    draw     = (lfsr * (last + 1)) >> 16;
                    position = int'(draw);
                end
                if (wrap)
                    eoc_left = eoc_ticks;
                if (gate_bit(position))
                begin
                    gate_level = 1'b1;
                    trig_left  = trig_ticks;
                    if (cv_mode == CV_SAMPLE)
                        load = 1'b1;
                end
                else
                begin
                    gate_level = 1'b0;
                    zero       = 1'b1;
                end
            end
            clock_prev = clock_level;

            if (cv_mode == CV_FOLLOW && position >= 0 && gate_bit(position))
                load = 1'b1;
            if (load)
                zero = 1'b0;

            r.gate_out   = gate_level;
            r.trig_out   = (trig_left != 0);
            r.eoc_out    = (eoc_left != 0);
            r.step_index = (position >= 0) ? position[LAST_W-1:0] : '0;
            r.step_valid = (position >= 0);
            r.cv_load    = load;
            r.cv_zero    = zero;
            expected_ticks.push_back(r);

            if (trig_left != 0)
                trig_left--;
            if (eoc_left != 0)
                eoc_left--;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_tick(logic [15:0] data);
            res_t got;
            res_t want;
            got = res_t'(data[$bits(res_t)-1:0]);
            checked++;
            if (expected_ticks.size() == 0)
            begin
                $error("result transaction with no input pending: %h", data);
                mismatches++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("gate_out",   want.gate_out,   got.gate_out);
            compare_field("trig_out",   want.trig_out,   got.trig_out);
            compare_field("eoc_out",    want.eoc_out,    got.eoc_out);
            compare_field("step_index", want.step_index, got.step_index);
            compare_field("step_valid", want.step_valid, got.step_valid);
            compare_field("cv_load",    want.cv_load,    got.cv_load);
            compare_field("cv_zero",    want.cv_zero,    got.cv_zero);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // clock_level, reset_level, reset_button, 0
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // gate_out, trig_out, eoc_out, step_index[3:0],
                                       // step_valid, cv_load, cv_zero, 0

    step_predictor predictor = new();
    bit            calm;
    bit            long_hold_done;

    gate_step_sequencer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // APB write: setup phase, access phase held until pready, then back to idle.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        predictor.set_reg(idx, value);
    endtask

    // Every item yields a result, so an empty queue means the pipe is empty.
    task automatic wait_drained();
        while (predictor.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input cfg_t setting);
        wait_drained();
        write_reg(REG_LAST_STEP,  DATA_W'(setting.last_step));
        write_reg(REG_PLAY_MODE,  DATA_W'(setting.play_mode));
        write_reg(REG_CV_MODE,    DATA_W'(setting.cv_mode));
        write_reg(REG_STEP_GATES, DATA_W'(setting.step_gates));
        write_reg(REG_TRIG_TICKS, DATA_W'(setting.trig_ticks));
        write_reg(REG_EOC_TICKS,  DATA_W'(setting.eoc_ticks));
    endtask

    // Offer one tick, optionally after a gap; tvalid stays high after acceptance.
    task automatic send_tick(input logic [2:0] bits);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {5'b0, bits};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predictor.take_tick(bits[0], bits[1], bits[2]);
    endtask

    // Mostly a clean clock with random high/low lengths and rare resets; some noise ticks.
    task automatic run_ticks(input int count);
        logic [2:0] bits;
        logic       clk_lvl;
        int         hold_left;
        clk_lvl   = 1'b0;
        hold_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                bits = 3'($urandom);
            else
            begin
                if (hold_left == 0)
                begin
                    clk_lvl   = !clk_lvl;
                    hold_left = $urandom_range(1, 3);
                end
                hold_left--;
                bits = {($urandom_range(0, 39) == 0), ($urandom_range(0, 24) == 0), clk_lvl};
            end
            send_tick(bits);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_opening(input cfg_t setting);
        apply_setting(setting);
        foreach (OPENING_TICKS[i])
            send_tick(OPENING_TICKS[i]);
        s_axis_tvalid <= 1'b0;
    endtask

    // Result side: every accepted transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            predictor.check_tick(m_axis_tdata);
    end

    // Receiver readiness: random stall bursts, one long hold so the input side backs
    // up, and no stalls once the run turns calm.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && predictor.checked >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without a stream transaction.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        cfg_t setting;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        calm           = 1'b0;
        long_hold_done = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening: short forward cycle with an unlit step, then reverse over the full
        // range in follow mode with no trigger pulse and the longest end-of-cycle pulse.
        setting = '{4'd2, PLAY_FWD, CV_SAMPLE, 16'h0005, 16'd2, 16'd3};
        run_opening(setting);
        setting = '{4'd15, PLAY_REV, CV_FOLLOW, 16'h8001, 16'd0, 16'hFFFF};
        run_opening(setting);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                // random draws over all 16 steps, leaves the position anywhere
                0: setting = '{4'd15, PLAY_RAND, CV_FOLLOW, 16'h5AA5, 16'd5, 16'd9};
                // reverse entered from above the new last step
                1: setting = '{4'd1, PLAY_REV, CV_SAMPLE, 16'h0002, 16'hFFFF, 16'd1};
                2: setting = '{4'd15, PLAY_RAND_ALT, CV_SAMPLE, 16'h3C3C, 16'd4, 16'd7};
                // single-step forward cycle, entered from above the last step
                3: setting = '{4'd0, PLAY_FWD, CV_FOLLOW, 16'hFFFF, 16'd1, 16'd1};
                default:
                begin
                    setting.last_step  = 4'($urandom_range(0, 15));
                    setting.play_mode  = 2'($urandom_range(0, 3));
                    setting.cv_mode    = 1'($urandom_range(0, 1));
                    setting.step_gates = 16'($urandom);
                    setting.trig_ticks = 16'($urandom_range(0, 20));
                    setting.eoc_ticks  = 16'($urandom_range(0, 40));
                end
            endcase
            apply_setting(setting);
            calm = (p == NUM_PHASES - 1);
            run_ticks(PHASE_TICKS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (predictor.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/gss_pkg.sv
sv/gss_apb_regs.sv
sv/gss_step_core.sv
sv/gate_step_sequencer.sv
bench/tb_gate_step_sequencer.sv
